// File: sv/r2h_pkg.sv
// Shared widths, constants and types of the RGB to HSV converter.
package r2h_pkg;

  localparam int unsigned CH_W = 8;
  localparam int unsigned HUE_W = 15;
  localparam int unsigned SAT_W = 13;
  localparam int unsigned SAT_FRAC = 13;

  localparam int unsigned DEN_W = CH_W + 1;
  localparam int unsigned QUO_W = 15;
  localparam int unsigned NUM_W = DEN_W + QUO_W;
  localparam int unsigned DIV_STAGES = 5;
  localparam int unsigned DIV_BITS_PER_STAGE = QUO_W / DIV_STAGES;
  localparam int unsigned PIPE_STAGES = DIV_STAGES + 3;

  localparam int HUE_PER_SIXTY = 3840;
  localparam logic [HUE_W-1:0] HUE_FULL_TURN = HUE_W'(6 * HUE_PER_SIXTY);
  localparam logic [HUE_W-1:0] HUE_OFS_GREEN = HUE_W'(2 * HUE_PER_SIXTY);
  localparam logic [HUE_W-1:0] HUE_OFS_BLUE = HUE_W'(4 * HUE_PER_SIXTY);
  localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(4096);

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  typedef logic [NUM_W-1:0] div_word_t;
  typedef logic [DEN_W-1:0] div_den_t;

endpackage

// File: sv/r2h_div_pipe.sv
// Pipelined restoring divider that retires three quotient bits in each stage.
module r2h_div_pipe (
  input  logic                             clk_i,
  input  logic [r2h_pkg::DIV_STAGES-1:0]   en_i,
  input  r2h_pkg::div_word_t               num_i,
  input  r2h_pkg::div_den_t                den_i,
  output logic [r2h_pkg::QUO_W-1:0]        quo_o
);
  import r2h_pkg::*;

  function automatic div_word_t div_step(input div_word_t w, input div_den_t d);
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    div_word_t      res;
    trial = {w[NUM_W-1:QUO_W], w[QUO_W-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      res = {diff[DEN_W-1:0], w[QUO_W-2:0], 1'b1};
    end else begin
      res = {trial[DEN_W-1:0], w[QUO_W-2:0], 1'b0};
    end
    return res;
  endfunction

  div_word_t w_q  [DIV_STAGES];
  div_den_t  d_q  [DIV_STAGES];
  div_word_t w_in [DIV_STAGES];
  div_den_t  d_in [DIV_STAGES];
  div_word_t w_d  [DIV_STAGES];

  always_comb begin
    w_in[0] = num_i;
    d_in[0] = den_i;
    for (int s = 1; s < DIV_STAGES; s++) begin
      w_in[s] = w_q[s-1];
      d_in[s] = d_q[s-1];
    end
  end

  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      w_d[s] = w_in[s];
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        w_d[s] = div_step(w_d[s], d_in[s]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en_i[s]) begin
        w_q[s] <= w_d[s];
        d_q[s] <= d_in[s];
      end
    end
  end

  assign quo_o = w_q[DIV_STAGES-1][QUO_W-1:0];

endmodule

// File: sv/rgb_to_hsv_converter.sv
// RGB to HSV converter top level with an eight-stage elastic pipeline.
// Throughput is one pixel per cycle while the output is not stalled; the five divider stages set the depth.
// A stalled output holds the run of full stages behind it up to the first empty stage, which still loads.
// Reset clears the valid bit of every stage; data registers are not reset.
module rgb_to_hsv_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [r2h_pkg::CH_W-1:0]    red_in_i,
  input  logic [r2h_pkg::CH_W-1:0]    green_in_i,
  input  logic [r2h_pkg::CH_W-1:0]    blue_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [r2h_pkg::HUE_W-1:0]   hue_out_o,
  output logic [r2h_pkg::SAT_W-1:0]   saturation_out_o,
  output logic [r2h_pkg::CH_W-1:0]    value_out_o
);
  import r2h_pkg::*;

  localparam int unsigned ACC_W = NUM_W + 2;
  localparam int unsigned LAST = PIPE_STAGES - 1;
  localparam logic signed [ACC_W-1:0] HueSixty = ACC_W'(HUE_PER_SIXTY);

  typedef struct packed {
    logic [CH_W-1:0] mx;
    logic            zero;
  } side_t;

  logic [PIPE_STAGES-1:0] v_q;
  logic [PIPE_STAGES-1:0] en;
  side_t                  side_q [LAST];

  // Stage 0: maximum, minimum, sector and channel difference.
  logic [CH_W-1:0]        mx_d, mn_d, delta_d;
  logic signed [CH_W:0]   n_d;
  sector_e                sec_d;
  logic [CH_W-1:0]        delta0_q;
  logic signed [CH_W:0]   n0_q;
  sector_e                sec0_q;

  // Stage 1: numerators and divisors.
  logic [HUE_W-1:0]        k_d;
  logic [HUE_W+CH_W-1:0]   kd_d;
  logic signed [ACC_W-1:0] acc_d;
  div_word_t               hnum_d, snum_d, hnum_q, snum_q;
  div_den_t                hden_q, sden_q;

  logic [QUO_W-1:0] hquo, squo;
  logic [HUE_W-1:0] hue_d, hue_q;
  logic [SAT_W-1:0] sat_d, sat_q;
  logic [CH_W-1:0]  val_q;

  always_comb begin
    en[LAST] = !v_q[LAST] || out_ready_i;
    for (int k = int'(LAST) - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    mx_d = red_in_i;
    if (green_in_i > mx_d) begin
      mx_d = green_in_i;
    end
    if (blue_in_i > mx_d) begin
      mx_d = blue_in_i;
    end
    mn_d = red_in_i;
    if (green_in_i < mn_d) begin
      mn_d = green_in_i;
    end
    if (blue_in_i < mn_d) begin
      mn_d = blue_in_i;
    end
    delta_d = mx_d - mn_d;
    if (red_in_i == mx_d) begin
      sec_d = SEC_RED;
      n_d   = $signed({1'b0, green_in_i}) - $signed({1'b0, blue_in_i});
    end else if (green_in_i == mx_d) begin
      sec_d = SEC_GREEN;
      n_d   = $signed({1'b0, blue_in_i}) - $signed({1'b0, red_in_i});
    end else begin
      sec_d = SEC_BLUE;
      n_d   = $signed({1'b0, red_in_i}) - $signed({1'b0, green_in_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      delta0_q       <= delta_d;
      n0_q           <= n_d;
      sec0_q         <= sec_d;
      side_q[0].mx   <= mx_d;
      side_q[0].zero <= (delta_d == '0);
    end
  end

  always_comb begin
    case (sec0_q)
      SEC_RED:   k_d = n0_q[CH_W] ? HUE_FULL_TURN : '0;
      SEC_GREEN: k_d = HUE_OFS_GREEN;
      SEC_BLUE:  k_d = HUE_OFS_BLUE;
      default:   k_d = '0;
    endcase
    kd_d   = k_d * delta0_q;
    acc_d  = {{(ACC_W-CH_W-1){n0_q[CH_W]}}, n0_q} * HueSixty + $signed(ACC_W'(kd_d));
    hnum_d = {acc_d[NUM_W-2:0], 1'b0} + NUM_W'(delta0_q);
    snum_d = NUM_W'({delta0_q, {SAT_FRAC{1'b0}}}) + NUM_W'(side_q[0].mx);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      hnum_q    <= hnum_d;
      snum_q    <= snum_d;
      hden_q    <= {delta0_q, 1'b0};
      sden_q    <= {side_q[0].mx, 1'b0};
      side_q[1] <= side_q[0];
    end
    for (int k = 2; k < LAST; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  r2h_div_pipe u_hue_div (
    .clk_i (clk_i),
    .en_i  (en[DIV_STAGES+1:2]),
    .num_i (hnum_q),
    .den_i (hden_q),
    .quo_o (hquo)
  );

  r2h_div_pipe u_sat_div (
    .clk_i (clk_i),
    .en_i  (en[DIV_STAGES+1:2]),
    .num_i (snum_q),
    .den_i (sden_q),
    .quo_o (squo)
  );

  always_comb begin
    if (side_q[LAST-1].zero) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = (hquo >= HUE_FULL_TURN) ? hquo - HUE_FULL_TURN : hquo;
      sat_d = squo[SAT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= side_q[LAST-1].mx;
    end
  end

  assign out_valid_o      = v_q[LAST];
  assign hue_out_o        = hue_q;
  assign saturation_out_o = sat_q;
  assign value_out_o      = val_q;

`ifndef SYNTHESIS
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("Accepted transaction did not reach the first stage.");

  a_black_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (value_out_o == '0) |-> (hue_out_o == '0) && (saturation_out_o == '0))
    else $error("Black pixel produced a non-zero hue or saturation.");

  a_grey_hue_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (saturation_out_o == '0) |-> (hue_out_o == '0))
    else $error("Grey pixel produced a non-zero hue.");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_out_o < HUE_FULL_TURN))
    else $error("Hue reached a full turn.");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (saturation_out_o <= SAT_ONE))
    else $error("Saturation exceeded one.");
`endif

endmodule

// File: verif/rgb_to_hsv_converter_tb.sv
// Self-checking testbench for the RGB to HSV converter with handshake and stall stimulus.
module rgb_to_hsv_converter_tb;

  import r2h_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRESSURE_CYCLES = 80;
  localparam int SETTLE_CYCLES = 2 * PIPE_STAGES + 4;
  localparam int N_DIRECTED = 23;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [CH_W-1:0]  val;
  } hsv_t;

  typedef struct packed {
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic             known;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [CH_W-1:0]  val;
  } pixel_row_t;

  // Rows with known set carry an expectation read straight off the definition.
  localparam pixel_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     13'd0,    8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 15'd0,     13'd0,    8'd255},
    '{8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     13'd0,    8'd128},
    '{8'd1,   8'd1,   8'd1,   1'b1, 15'd0,     13'd0,    8'd1},
    '{8'd255, 8'd0,   8'd0,   1'b1, 15'd0,     13'd4096, 8'd255},
    '{8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  13'd4096, 8'd255},
    '{8'd0,   8'd0,   8'd255, 1'b1, 15'd15360, 13'd4096, 8'd255},
    '{8'd255, 8'd255, 8'd0,   1'b1, 15'd3840,  13'd4096, 8'd255},
    '{8'd0,   8'd255, 8'd255, 1'b1, 15'd11520, 13'd4096, 8'd255},
    '{8'd255, 8'd0,   8'd255, 1'b1, 15'd19200, 13'd4096, 8'd255},
    '{8'd1,   8'd0,   8'd0,   1'b1, 15'd0,     13'd4096, 8'd1},
    '{8'd255, 8'd0,   8'd1,   1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd255, 8'd254, 8'd254, 1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd254, 8'd255, 8'd255, 1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd255, 8'd255, 8'd254, 1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd255, 8'd254, 8'd255, 1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd2,   8'd1,   8'd0,   1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd1,   8'd2,   8'd3,   1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd3,   8'd0,   8'd2,   1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd170, 8'd85,  8'd255, 1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd85,  8'd170, 8'd0,   1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd15,  8'd240, 8'd60,  1'b0, 15'd0,     13'd0,    8'd0},
    '{8'd254, 8'd253, 8'd255, 1'b0, 15'd0,     13'd0,    8'd0}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [CH_W-1:0] red_in_i = '0;
  logic [CH_W-1:0] green_in_i = '0;
  logic [CH_W-1:0] blue_in_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [HUE_W-1:0] hue_out_o;
  logic [SAT_W-1:0] saturation_out_o;
  logic [CH_W-1:0]  value_out_o;

  pixel_row_t pixel_q [$];
  hsv_t       hsv_expect_q [$];
  pixel_row_t offered_row;

  bit run_en = 1'b0;
  bit pressure_go = 1'b0;
  bit pressure_done = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  int sent_count = 0;
  int checked_count = 0;
  int input_stalls = 0;
  int err_count = 0;

  rgb_to_hsv_converter u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .red_in_i         (red_in_i),
    .green_in_i       (green_in_i),
    .blue_in_i        (blue_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hue_out_o        (hue_out_o),
    .saturation_out_o (saturation_out_o),
    .value_out_o      (value_out_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic hsv_t hsv_of_pixel(input logic [CH_W-1:0] r, g, b);
    hsv_t    res;
    int      rv, gv, bv, mx, mn, dl, n, k, num, h;
    sector_e sec;
    rv = int'(r);
    gv = int'(g);
    bv = int'(b);
    mx = (rv > gv) ? rv : gv;
    mx = (mx > bv) ? mx : bv;
    mn = (rv < gv) ? rv : gv;
    mn = (mn < bv) ? mn : bv;
    dl = mx - mn;
    res.val = CH_W'(mx);
    res.hue = '0;
    res.sat = '0;
    if (mx != 0 && dl != 0) begin
      res.sat = SAT_W'((8192 * dl + mx) / (2 * mx));
      if (rv == mx) sec = SEC_RED;
      else if (gv == mx) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      case (sec)
        SEC_RED: begin
          n = gv - bv;
          k = (n < 0) ? int'(HUE_FULL_TURN) : 0;
        end
        SEC_GREEN: begin
          n = bv - rv;
          k = int'(HUE_OFS_GREEN);
        end
        default: begin
          n = rv - gv;
          k = int'(HUE_OFS_BLUE);
        end
      endcase
      num = HUE_PER_SIXTY * n + k * dl;
      h = (2 * num + dl) / (2 * dl);
      if (h >= int'(HUE_FULL_TURN)) h = h - int'(HUE_FULL_TURN);
      res.hue = HUE_W'(h);
    end
    return res;
  endfunction

  function automatic pixel_row_t random_pixel();
    pixel_row_t p;
    int         pick;
    p = '0;
    pick = $urandom_range(99);
    if (pick < 50) begin
      p.r = CH_W'($urandom);
      p.g = CH_W'($urandom);
      p.b = CH_W'($urandom);
    end else if (pick < 65) begin
      p.r = CH_W'($urandom);
      p.g = p.r - CH_W'($urandom_range(1) * ((p.r != 0) ? 1 : 0));
      p.b = p.r - CH_W'($urandom_range(1) * ((p.r != 0) ? 1 : 0));
    end else if (pick < 80) begin
      p.r = CH_W'($urandom);
      p.g = CH_W'($urandom);
      p.b = CH_W'($urandom);
      case ($urandom_range(2))
        0: p.g = p.r;
        1: p.b = p.g;
        default: p.r = p.b;
      endcase
    end else if (pick < 90) begin
      p.r = CH_W'($urandom_range(3));
      p.g = CH_W'($urandom_range(3));
      p.b = CH_W'($urandom_range(3));
    end else begin
      p.r = $urandom_range(1) ? 8'd255 : 8'd0;
      p.g = $urandom_range(1) ? 8'd255 : CH_W'($urandom_range(1));
      p.b = $urandom_range(1) ? 8'd254 : 8'd0;
    end
    return p;
  endfunction

  task automatic report_error(input string msg);
    $display("rgb_to_hsv_converter_tb: %s", msg);
    err_count++;
  endtask

  task automatic add_random_pixels(input int count);
    for (int i = 0; i < count; i++) pixel_q.push_back(random_pixel());
  endtask

  task automatic wait_pixels_sent();
    while (pixel_q.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      if (offered_row.known) begin
        hsv_expect_q.push_back({offered_row.hue, offered_row.sat, offered_row.val});
      end else begin
        hsv_expect_q.push_back(hsv_of_pixel(red_in_i, green_in_i, blue_in_i));
      end
      sent_count++;
    end else if (in_valid_i) begin
      input_stalls++;
    end
    if (!run_en) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered_row = pixel_q.pop_front();
        in_valid_i <= 1'b1;
        red_in_i <= offered_row.r;
        green_in_i <= offered_row.g;
        blue_in_i <= offered_row.b;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hsv_expect_q.size() == 0) begin
        report_error($sformatf("result hue %0d sat %0d value %0d with no transaction pending",
                               hue_out_o, saturation_out_o, value_out_o));
      end else begin
        want = hsv_expect_q.pop_front();
        if (hue_out_o !== want.hue)
          report_error($sformatf("result %0d hue %0d, expected %0d",
                                 checked_count, hue_out_o, want.hue));
        if (saturation_out_o !== want.sat)
          report_error($sformatf("result %0d saturation %0d, expected %0d",
                                 checked_count, saturation_out_o, want.sat));
        if (value_out_o !== want.val)
          report_error($sformatf("result %0d value %0d, expected %0d",
                                 checked_count, value_out_o, want.val));
      end
      checked_count++;
    end
    if (!run_en) begin
      out_ready_i <= 1'b0;
    end else if (pressure_go && !pressure_done) begin
      if (hold_cnt == PRESSURE_CYCLES) begin
        pressure_done <= 1'b1;
        out_ready_i <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt + 1;
        out_ready_i <= 1'b0;
      end
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (run_en) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("rgb_to_hsv_converter_tb: no transaction for %0d cycles", idle_cycles);
        $display("rgb_to_hsv_converter_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    run_en = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) pixel_q.push_back(DIRECTED_ROWS[i]);
    add_random_pixels(150);
    wait_pixels_sent();

    send_idle_pct = 71;
    add_random_pixels(130);
    wait_pixels_sent();

    send_idle_pct = 0;
    recv_stall_pct = 71;
    add_random_pixels(130);
    wait_pixels_sent();

    send_idle_pct = 24;
    recv_stall_pct = 24;
    add_random_pixels(130);
    wait_pixels_sent();

    // The output is held off while pixels keep coming, so the pipeline fills.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pressure_go = 1'b1;
    add_random_pixels(60);
    while (!pressure_done) @(negedge clk_i);
    wait_pixels_sent();

    add_random_pixels(40);
    wait_pixels_sent();

    while (hsv_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("rgb_to_hsv_converter_tb: %0d pixels sent and %0d results checked",
             sent_count, checked_count);
    $display("rgb_to_hsv_converter_tb: idling phases, %0d stalled input cycles, %0d mismatches",
             input_stalls, err_count);
    if (err_count == 0) begin
      $display("rgb_to_hsv_converter_tb: done, clean");
    end else begin
      $display("rgb_to_hsv_converter_tb: done, errors");
    end
    $finish;
  end

endmodule
